>>> hdl/ilist_pkg.sv
// Shared definitions for the indexed doubly linked list block.
// Holds operation codes, field widths and the controller/datapath handshake structs.
// No dependencies.
package ilist_pkg;

  localparam int SLOT_W = 6;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_UNLINK = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // capture the incoming word, launch link reads
    logic work;       // perform the operation on the read links
    logic tail_clear; // second append step: null the new tail's next link
    logic load_live;  // load the result word from this cycle's values
    logic hold_store; // park the follower fields while the output is busy
    logic load_hold;  // load the result word from the parked fields
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic two_step;   // append onto a non-empty list needs a second write
    logic out_free;   // output register can take a word this cycle
  } status_t;

endpackage

>>> hdl/ilist_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ilist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ilist_ctrl.sv
// Controller for the indexed doubly linked list: sequences accept, work,
// optional second append write and result delivery. Depends on ilist_pkg.
module ilist_ctrl
  import ilist_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        cmd.work = 1'b1;
        if (status.two_step) begin
          state_next = ST_TAIL;
        end else if (status.out_free) begin
          cmd.load_live = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.hold_store = 1'b1;
          state_next     = ST_HOLD;
        end
      end
      ST_TAIL: begin
        cmd.tail_clear = 1'b1;
        if (status.out_free) begin
          cmd.load_live = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.hold_store = 1'b1;
          state_next     = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status.out_free) begin
          cmd.load_hold = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/ilist_dp.sv
// Datapath for the indexed doubly linked list: head/tail registers, link RAMs,
// item capture and the output register. Depends on ilist_pkg and ilist_ram.
module ilist_dp
  import ilist_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [OP_W-1:0]   op,
  input  logic [SLOT_W-1:0] slot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] following_slot,
  output logic              following_present,
  output logic [SLOT_W-1:0] head_slot,
  output logic [SLOT_W-1:0] tail_slot,
  output logic              list_empty
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int LW = IW + 1;  // link entry: valid bit on top of the index

  // Captured item
  logic [OP_W-1:0] op_q;
  logic [IW-1:0]   slot_q;
  logic            range_q;

  // List ends
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic          empty;
  logic [IW-1:0] head_next;
  logic [IW-1:0] tail_next;
  logic          empty_next;

  // Link RAM ports
  logic          prev_we;
  logic [IW-1:0] prev_waddr;
  logic [LW-1:0] prev_wdata;
  logic [LW-1:0] prev_rdata;
  logic          next_we;
  logic [IW-1:0] next_waddr;
  logic [LW-1:0] next_wdata;
  logic [LW-1:0] next_rdata;
  logic [IW-1:0] rd_addr;

  // Follower fields
  logic              fol_present;
  logic [SLOT_W-1:0] fol_slot;
  logic              hold_present;
  logic [SLOT_W-1:0] hold_slot;

  logic          pv;
  logic [IW-1:0] p;
  logic          nv;
  logic [IW-1:0] n;
  logic          is_head;
  logic          is_tail;

  assign rd_addr = IW'(slot);

  ilist_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (prev_rdata)
  );

  ilist_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (next_rdata)
  );

  assign pv = prev_rdata[LW-1];
  assign p  = prev_rdata[IW-1:0];
  assign nv = next_rdata[LW-1];
  assign n  = next_rdata[IW-1:0];

  assign is_head = !empty && (head == slot_q);
  assign is_tail = !empty && (tail == slot_q);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty;
    prev_we     = 1'b0;
    prev_waddr  = slot_q;
    prev_wdata  = '0;
    next_we     = 1'b0;
    next_waddr  = slot_q;
    next_wdata  = '0;
    fol_present = 1'b0;
    fol_slot    = '0;
    if (cmd.work && range_q) begin
      unique case (op_q)
        OP_APPEND: begin
          if (empty) begin
            prev_we    = 1'b1;
            next_we    = 1'b1;
            head_next  = slot_q;
            tail_next  = slot_q;
            empty_next = 1'b0;
          end else begin
            next_we    = 1'b1;
            next_waddr = tail;
            next_wdata = {1'b1, slot_q};
            prev_we    = 1'b1;
            prev_wdata = {1'b1, tail};
            tail_next  = slot_q;
          end
        end
        OP_UNLINK: begin
          if (is_head && is_tail) begin
            empty_next = 1'b1;
          end else if (is_head) begin
            if (!nv) begin
              empty_next = 1'b1;
            end else begin
              head_next  = n;
              prev_we    = 1'b1;
              prev_waddr = n;
            end
          end else if (is_tail) begin
            if (!pv) begin
              empty_next = 1'b1;
            end else begin
              tail_next  = p;
              next_we    = 1'b1;
              next_waddr = p;
            end
          end else begin
            next_we    = pv;
            next_waddr = p;
            next_wdata = {nv, n};
            prev_we    = nv;
            prev_waddr = n;
            prev_wdata = {pv, p};
          end
        end
        OP_QUERY: begin
          fol_present = nv;
          fol_slot    = nv ? SLOT_W'(n) : '0;
        end
        default: ;
      endcase
    end
    // second append step: the new tail ends the chain
    if (cmd.tail_clear) begin
      next_we = 1'b1;
    end
  end

  assign status.two_step = (op_q == OP_APPEND) && range_q && !empty;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b1;
    end else begin
      empty <= empty_next;
    end
    head <= head_next;
    tail <= tail_next;
    if (cmd.accept) begin
      op_q    <= op;
      slot_q  <= IW'(slot);
      range_q <= (32'(slot) < SLOT_COUNT);
    end
    if (cmd.hold_store) begin
      hold_present <= fol_present;
      hold_slot    <= fol_slot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_live || cmd.load_hold) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_live) begin
      following_slot    <= fol_slot;
      following_present <= fol_present;
      head_slot         <= empty_next ? '0 : SLOT_W'(head_next);
      tail_slot         <= empty_next ? '0 : SLOT_W'(tail_next);
      list_empty        <= empty_next;
    end else if (cmd.load_hold) begin
      following_slot    <= hold_slot;
      following_present <= hold_present;
      head_slot         <= empty ? '0 : SLOT_W'(head);
      tail_slot         <= empty ? '0 : SLOT_W'(tail);
      list_empty        <= empty;
    end
  end

endmodule

>>> hdl/indexed_doubly_linked_list.sv
// Top level of the indexed doubly linked list block.
// Depends on ilist_pkg, ilist_ctrl, ilist_dp (and ilist_ram through ilist_dp).
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per operation:
//   op = append slot at tail, unlink slot, or query the slot that follows.
//   Output channel (out_valid / out_stall) returns exactly one word per
//   input word: the follower (query only), head, tail and the empty flag,
//   all as they stand after the operation.
//   The result word is loaded into the output register in the work step,
//   or in the second append write for an append onto a non-empty list.
//   The block takes no new word while the previous one is still being
//   worked: the link RAMs have a registered read (read when the word is
//   taken, update in the work step), and the next-link RAM has a single
//   write port, which an append onto a non-empty list must hit twice.
//   A new input word is taken while the previous result still waits in
//   the output register; if the receiver keeps stalling, the finished
//   result is parked and the block holds in_stall high until it leaves.
//   Reset empties the list and drops any pending result. Link RAM contents
//   are not cleared; every link is written before the list reaches it.
module indexed_doubly_linked_list
  import ilist_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   op,
  input  logic [SLOT_W-1:0] slot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] following_slot,
  output logic              following_present,
  output logic [SLOT_W-1:0] head_slot,
  output logic [SLOT_W-1:0] tail_slot,
  output logic              list_empty
);

  cmd_t    cmd;
  status_t status;

  // Sequencer: accept, work, optional tail write, deliver or park.
  ilist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Link storage, list ends and the output register.
  ilist_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .op                (op),
    .slot              (slot),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .following_slot    (following_slot),
    .following_present (following_present),
    .head_slot         (head_slot),
    .tail_slot         (tail_slot),
    .list_empty        (list_empty)
  );

endmodule
